>>> rtl/core/indexed_insert_erase_array_unit_defines.svh
// Assertion macros for the indexed insert/erase array unit.
// Included by the top level; no other dependencies.
`ifndef INDEXED_INSERT_ERASE_ARRAY_UNIT_DEFINES_SVH
`define INDEXED_INSERT_ERASE_ARRAY_UNIT_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define IIEA_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
`define IIEA_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define IIEA_ASSERT(lbl, prop, msg)
`define IIEA_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

>>> rtl/core/iiea_pkg.sv
// Shared types and constants of the indexed insert/erase array unit.
// No dependencies; imported by every module of the unit.
package iiea_pkg;
	localparam int DEPTH = 16;
	localparam int DATA_W = 32;
	localparam int OP_W = 4;
	localparam int IDX_W = 5;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam int AW = $clog2(DEPTH);

	typedef enum logic [OP_W-1:0] {
		OP_INSERT_AT  = 4'd0,
		OP_PUSH_FRONT = 4'd1,
		OP_PUSH_BACK  = 4'd2,
		OP_REMOVE_AT  = 4'd3,
		OP_POP_FRONT  = 4'd4,
		OP_POP_BACK   = 4'd5,
		OP_READ_AT    = 4'd6,
		OP_FRONT      = 4'd7,
		OP_BACK       = 4'd8,
		OP_CLEAR      = 4'd9
	} op_t;

	typedef enum logic [1:0] {
		CELL_HOLD,
		CELL_OPEN,
		CELL_CLOSE
	} cell_kind_t;

	// Broadcast from the controller to every cell of the chain.
	typedef struct packed {
		cell_kind_t         kind;
		logic [CNT_W-1:0]   pos;
		logic [CNT_W-1:0]   count;
		logic [DATA_W-1:0]  value;
	} cell_cmd_t;

	typedef logic [DEPTH-1:0][DATA_W-1:0] entry_vec_t;
endpackage

>>> rtl/core/indexed_insert_erase_array_unit.sv
// Top level of the indexed insert/erase array unit: controller plus cell chain.
// Depends on iiea_pkg, iiea_ctrl, iiea_cell and the assertion macro header.
//
// This unit keeps an ordered array of up to DEPTH (16) words of 32 bits and a
// fill count. Each input transaction is one operation: insert at an index,
// push front or push back opens a gap and stores the value; remove at an
// index, pop front or pop back returns the entry and closes the gap; read at,
// front and back return an entry unchanged; clear empties the array. Every
// operation produces exactly one result transaction carrying a success flag,
// the returned word (zero when nothing is returned) and the count after the
// operation. Failed operations and unknown operation codes change nothing.
// The storage is a row of identical cells, each holding one entry and loading
// from its lower or upper neighbor, so a whole insert or remove shift is done
// at the clock edge that accepts the transaction. The unit takes one
// operation per cycle; its result appears in the output register on the next
// cycle, and a new operation is accepted in the same cycle that the previous
// result is taken. Input is stalled only while an untaken result is held with
// the output stalled. Entries hold no reset value; only entries below the
// fill count are ever read.
`include "indexed_insert_erase_array_unit_defines.svh"
module indexed_insert_erase_array_unit
	import iiea_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [OP_W-1:0]   operation,
	input  logic [IDX_W-1:0]  index,
	input  logic [DATA_W-1:0] value,
	output logic              out_valid,
	input  logic              out_stall,
	output logic              ok,
	output logic [DATA_W-1:0] data_out,
	output logic [CNT_W-1:0]  entry_count
);
	logic       accept;
	logic       out_take;
	cell_cmd_t  cmd;
	entry_vec_t entries;

	// The output register is freed by a taken result, so a new transaction
	// can enter in the same cycle.
	assign out_take = out_valid && !out_stall;
	assign in_stall = out_valid && out_stall;
	assign accept = in_valid && !in_stall;

	iiea_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.accept     (accept),
		.out_take   (out_take),
		.operation  (operation),
		.index      (index),
		.value      (value),
		.entries    (entries),
		.cmd        (cmd),
		.out_valid  (out_valid),
		.ok         (ok),
		.data_out   (data_out),
		.entry_count(entry_count)
	);

	// The chain: each cell sees its neighbors' words; the ends see zero.
	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic [DATA_W-1:0] lower_w;
		logic [DATA_W-1:0] upper_w;

		if (i == 0) begin : g_first
			assign lower_w = '0;
		end else begin : g_lower
			assign lower_w = entries[i-1];
		end
		if (i == DEPTH - 1) begin : g_last
			assign upper_w = '0;
		end else begin : g_upper
			assign upper_w = entries[i+1];
		end

		iiea_cell u_cell (
			.clk       (clk),
			.position  (AW'(i)),
			.cmd       (cmd),
			.lower_data(lower_w),
			.upper_data(upper_w),
			.data      (entries[i])
		);
	end

	// The count never goes past the capacity.
	`IIEA_ASSERT(a_count_bound, entry_count <= CNT_W'(DEPTH), "fill count above capacity")
	// Every accepted transaction leaves a result in the output register.
	`IIEA_ASSERT(a_result_follows, accept |=> out_valid, "accepted operation gave no result")
	// A clear always succeeds and empties the array.
	`IIEA_ASSERT(a_clear_empties, (accept && operation == OP_CLEAR) |=> (ok && entry_count == '0),
		"clear did not empty the array")
	// A failed operation leaves the count where it was.
	`IIEA_ASSERT(a_fail_holds, (out_valid && !ok && $past(accept)) |-> $stable(entry_count),
		"failed operation changed the count")
	// A clock edge seen in reset leaves no result pending at the following edge.
	`IIEA_ASSERT_ALWAYS(a_reset_idle, !arst_n |=> !out_valid, "result pending in reset")
endmodule

>>> rtl/core/iiea_cell.sv
// One storage cell of the shifting chain.
// Depends on iiea_pkg for the command struct and widths.
module iiea_cell
	import iiea_pkg::*;
(
	input  logic              clk,
	input  logic [AW-1:0]     position,
	input  cell_cmd_t         cmd,
	input  logic [DATA_W-1:0] lower_data,
	input  logic [DATA_W-1:0] upper_data,
	output logic [DATA_W-1:0] data
);
	logic [DATA_W-1:0] data_q;
	logic [CNT_W-1:0]  here;
	logic [CNT_W-1:0]  next_up;

	assign here = CNT_W'(position);
	assign next_up = here + CNT_W'(1);
	assign data = data_q;

	always_ff @(posedge clk) begin
		case (cmd.kind)
			CELL_OPEN: begin
				if (here == cmd.pos) begin
					data_q <= cmd.value;
				end else if (here > cmd.pos && here <= cmd.count) begin
					data_q <= lower_data;
				end
			end
			CELL_CLOSE: begin
				if (here >= cmd.pos && next_up < cmd.count) begin
					data_q <= upper_data;
				end
			end
			default: begin
			end
		endcase
	end
endmodule

>>> rtl/core/iiea_ctrl.sv
// Operation decode, fill count and result register of the array unit.
// Depends on iiea_pkg; drives the cell chain through a broadcast command.
module iiea_ctrl
	import iiea_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              accept,
	input  logic              out_take,
	input  logic [OP_W-1:0]   operation,
	input  logic [IDX_W-1:0]  index,
	input  logic [DATA_W-1:0] value,
	input  entry_vec_t        entries,
	output cell_cmd_t         cmd,
	output logic              out_valid,
	output logic              ok,
	output logic [DATA_W-1:0] data_out,
	output logic [CNT_W-1:0]  entry_count
);
	logic [CNT_W-1:0]  count_q;
	logic              out_valid_q;
	logic              ok_q;
	logic [DATA_W-1:0] data_q;
	logic [CNT_W-1:0]  idx_c;
	logic [CNT_W-1:0]  last_c;
	logic [CNT_W-1:0]  pos_c;
	logic [CNT_W-1:0]  count_c;
	logic              ok_c;
	logic              rd_c;
	logic              full_c;
	cell_kind_t        kind_c;

	assign idx_c = CNT_W'(index);
	assign last_c = count_q - CNT_W'(1);
	assign full_c = (count_q == CNT_W'(DEPTH));

	always_comb begin
		pos_c = '0;
		ok_c = 1'b0;
		rd_c = 1'b0;
		kind_c = CELL_HOLD;
		count_c = count_q;
		case (op_t'(operation))
			OP_INSERT_AT, OP_PUSH_FRONT, OP_PUSH_BACK: begin
				if (op_t'(operation) == OP_INSERT_AT) begin
					pos_c = idx_c;
				end else if (op_t'(operation) == OP_PUSH_BACK) begin
					pos_c = count_q;
				end
				ok_c = (pos_c <= count_q) && !full_c;
				if (ok_c) begin
					kind_c = CELL_OPEN;
					count_c = count_q + CNT_W'(1);
				end
			end
			OP_REMOVE_AT, OP_POP_FRONT, OP_POP_BACK,
			OP_READ_AT, OP_FRONT, OP_BACK: begin
				if (op_t'(operation) == OP_REMOVE_AT || op_t'(operation) == OP_READ_AT) begin
					pos_c = idx_c;
				end else if (op_t'(operation) == OP_POP_BACK
					|| op_t'(operation) == OP_BACK) begin
					pos_c = last_c;
				end
				ok_c = (count_q != '0) && (pos_c < count_q);
				rd_c = ok_c;
				if (ok_c && (op_t'(operation) == OP_REMOVE_AT
					|| op_t'(operation) == OP_POP_FRONT
					|| op_t'(operation) == OP_POP_BACK)) begin
					kind_c = CELL_CLOSE;
					count_c = last_c;
				end
			end
			OP_CLEAR: begin
				ok_c = 1'b1;
				count_c = '0;
			end
			default: begin
			end
		endcase
	end

	always_comb begin
		cmd.kind = accept ? kind_c : CELL_HOLD;
		cmd.pos = pos_c;
		cmd.count = count_q;
		cmd.value = value;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				count_q <= count_c;
				out_valid_q <= 1'b1;
			end else if (out_take) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Result payload; position is known to be below the count when read.
	always_ff @(posedge clk) begin
		if (accept) begin
			ok_q <= ok_c;
			data_q <= rd_c ? entries[pos_c[AW-1:0]] : '0;
		end
	end

	assign out_valid = out_valid_q;
	assign ok = ok_q;
	assign data_out = data_q;
	assign entry_count = count_q;
endmodule

>>> test/indexed_insert_erase_array_checker.sv
// Checker for the indexed insert/erase array unit: watches both channels, keeps a shadow
// copy of the array, predicts each result and compares it field by field.
// Depends on iiea_pkg for widths, the array depth and the operation codes.
module indexed_insert_erase_array_checker
	import iiea_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic              in_stall,
	input  logic [OP_W-1:0]   operation,
	input  logic [IDX_W-1:0]  index,
	input  logic [DATA_W-1:0] value,
	input  logic              out_valid,
	input  logic              out_stall,
	input  logic              ok,
	input  logic [DATA_W-1:0] data_out,
	input  logic [CNT_W-1:0]  entry_count,
	output int                mismatches,
	output int                pending
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic              ok;
		logic [DATA_W-1:0] data;
		logic [CNT_W-1:0]  count;
	} array_result_t;

	logic [DATA_W-1:0] shadow_words [DEPTH];
	int                shadow_level;
	array_result_t     awaited_results [$];

	initial begin
		mismatches = 0;
		pending = 0;
		shadow_level = 0;
	end

	// Applies one operation to the shadow array and returns the result it should produce.
	function automatic array_result_t apply_operation(input logic [OP_W-1:0] opcode,
			input logic [IDX_W-1:0] idx, input logic [DATA_W-1:0] word);
		array_result_t r;
		int pos;
		r = '0;
		pos = 0;
		case (op_t'(opcode))
			OP_INSERT_AT, OP_PUSH_FRONT, OP_PUSH_BACK: begin
				pos = (opcode == OP_INSERT_AT) ? int'(idx) :
					(opcode == OP_PUSH_FRONT) ? 0 : shadow_level;
				if (pos <= shadow_level && shadow_level < DEPTH) begin
					for (int i = shadow_level; i > pos; i--)
						shadow_words[i] = shadow_words[i-1];
					shadow_words[pos] = word;
					shadow_level++;
					r.ok = 1'b1;
				end
			end
			OP_REMOVE_AT, OP_POP_FRONT, OP_POP_BACK: begin
				if (shadow_level != 0) begin
					pos = (opcode == OP_REMOVE_AT) ? int'(idx) :
						(opcode == OP_POP_FRONT) ? 0 : shadow_level - 1;
					if (pos < shadow_level) begin
						r.data = shadow_words[pos];
						for (int i = pos; i + 1 < shadow_level; i++)
							shadow_words[i] = shadow_words[i+1];
						shadow_level--;
						r.ok = 1'b1;
					end
				end
			end
			OP_READ_AT, OP_FRONT, OP_BACK: begin
				if (shadow_level != 0) begin
					pos = (opcode == OP_READ_AT) ? int'(idx) :
						(opcode == OP_FRONT) ? 0 : shadow_level - 1;
					if (pos < shadow_level) begin
						r.data = shadow_words[pos];
						r.ok = 1'b1;
					end
				end
			end
			OP_CLEAR: begin
				shadow_level = 0;
				r.ok = 1'b1;
			end
			default: begin
			end
		endcase
		r.count = CNT_W'(shadow_level);
		return r;
	endfunction

	task automatic compare_field(input string field, input logic [DATA_W-1:0] want,
			input logic [DATA_W-1:0] got);
		if (got !== want) begin
			mismatches++;
			$display("%0t: %s mismatch, expected %h, actual %h", $time, field, want, got);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		array_result_t want;
		if (!arst_n) begin
			shadow_level = 0;
			awaited_results.delete();
		end else begin
			// A result taken at this edge belongs to an earlier operation, so it is
			// checked before the operation taken at the same edge is predicted.
			if (out_valid && !out_stall) begin
				if (awaited_results.size() == 0) begin
					mismatches++;
					$display("%0t: unexpected result, expected none, actual ok %b data_out %h entry_count %0d",
						$time, ok, data_out, entry_count);
				end else begin
					want = awaited_results.pop_front();
					compare_field("ok", DATA_W'(want.ok), DATA_W'(ok));
					compare_field("data_out", want.data, data_out);
					compare_field("entry_count", DATA_W'(want.count), DATA_W'(entry_count));
				end
			end
			if (in_valid && !in_stall)
				awaited_results.push_back(apply_operation(operation, index, value));
		end
		pending = awaited_results.size();
	end
endmodule

>>> test/indexed_insert_erase_array_unit_tb.sv
// Testbench top for the indexed insert/erase array unit: clock, reset, stimulus and verdict.
// Depends on iiea_pkg, the unit itself and indexed_insert_erase_array_checker.
module indexed_insert_erase_array_unit_tb;
	import iiea_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	// Cycles without any transaction on either channel before the run is declared hung.
	// The worst stall runs of the random idling are far shorter than this limit, so it is
	// many times what the slowest correct run could ever need.
	localparam int HANG_LIMIT = 2000;
	localparam int ITEMS_PER_PHASE = 370;

	typedef enum {BURST_FILL, BURST_DRAIN, BURST_MIXED} burst_kind_t;

	logic              clk;
	logic              arst_n;
	logic              in_valid;
	logic              in_stall;
	logic [OP_W-1:0]   operation;
	logic [IDX_W-1:0]  index;
	logic [DATA_W-1:0] value;
	logic              out_valid;
	logic              out_stall;
	logic              ok;
	logic [DATA_W-1:0] data_out;
	logic [CNT_W-1:0]  entry_count;

	int mismatches;
	int pending;

	// Percent of cycles in which the sender holds back and the receiver stalls.
	int sender_idle_pct;
	int receiver_stall_pct;

	indexed_insert_erase_array_unit dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.operation   (operation),
		.index       (index),
		.value       (value),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.ok          (ok),
		.data_out    (data_out),
		.entry_count (entry_count)
	);

	// The checker sees exactly what the unit sees and reports its mismatch count and
	// the number of results still owed back to this module.
	indexed_insert_erase_array_checker checker_inst (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.operation   (operation),
		.index       (index),
		.value       (value),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.ok          (ok),
		.data_out    (data_out),
		.entry_count (entry_count),
		.mismatches  (mismatches),
		.pending     (pending)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// The receiver decides at every falling edge whether to stall the next result.
	// The stall is allowed to change freely because it belongs to the receiving side.
	initial begin
		out_stall = 1'b0;
		forever begin
			@(negedge clk);
			out_stall <= ($urandom_range(0, 99) < receiver_stall_pct);
		end
	end

	// Watchdog: any transaction on either channel restarts the count.
	initial begin
		int quiet_cycles;
		quiet_cycles = 0;
		while (quiet_cycles < HANG_LIMIT) begin
			@(posedge clk);
			if ((in_valid && !in_stall) || (out_valid && !out_stall))
				quiet_cycles = 0;
			else
				quiet_cycles++;
		end
		$display("Test completed with failures");
		$finish;
	end

	// Offers one operation and returns once the unit has taken the transaction. The
	// sender may hold back for some cycles first; each falling edge assigns in_valid at
	// most once, so a valid that stays high between transactions is never toggled.
	task automatic issue_operation(input logic [OP_W-1:0] opcode, input logic [IDX_W-1:0] idx,
			input logic [DATA_W-1:0] word);
		@(negedge clk);
		while ($urandom_range(0, 99) < sender_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		operation <= opcode;
		index <= idx;
		value <= word;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
	endtask

	// Holds the sender back until every result owed by the unit has been taken.
	task automatic wait_for_results;
		@(negedge clk);
		in_valid <= 1'b0;
		while (pending != 0)
			@(negedge clk);
	endtask

	// Random traffic in bursts. Fill bursts are mostly inserts and drive the array to full,
	// drain bursts are mostly removals and drive it to empty, mixed bursts stir everything,
	// including clears. A small share of unknown operation codes lands in every burst.
	task automatic run_random_phase(input int idle_pct, input int stall_pct, input int items);
		burst_kind_t kind;
		int burst_len;
		int insert_cut;
		int remove_cut;
		int roll;
		int sent;
		logic [OP_W-1:0]   opcode;
		logic [IDX_W-1:0]  idx;
		logic [DATA_W-1:0] word;
		sender_idle_pct = idle_pct;
		receiver_stall_pct = stall_pct;
		sent = 0;
		while (sent < items) begin
			kind = burst_kind_t'($urandom_range(0, 2));
			burst_len = $urandom_range(16, 48);
			case (kind)
				BURST_FILL: begin
					insert_cut = 70;
					remove_cut = 85;
				end
				BURST_DRAIN: begin
					insert_cut = 15;
					remove_cut = 85;
				end
				default: begin
					insert_cut = 38;
					remove_cut = 70;
				end
			endcase
			for (int n = 0; n < burst_len && sent < items; n++) begin
				roll = $urandom_range(0, 99);
				if (roll < 2)
					opcode = OP_W'($urandom_range(OP_CLEAR + 1, (1 << OP_W) - 1));
				else if (kind == BURST_MIXED && roll < 4)
					opcode = OP_CLEAR;
				else begin
					roll = $urandom_range(0, 99);
					if (roll < insert_cut)
						opcode = op_t'($urandom_range(OP_INSERT_AT, OP_PUSH_BACK));
					else if (roll < remove_cut)
						opcode = op_t'($urandom_range(OP_REMOVE_AT, OP_POP_BACK));
					else
						opcode = op_t'($urandom_range(OP_READ_AT, OP_BACK));
				end
				// Most indexes fall in the legal span; some use the full field width.
				if ($urandom_range(0, 99) < 10)
					idx = IDX_W'($urandom_range(0, (1 << IDX_W) - 1));
				else
					idx = IDX_W'($urandom_range(0, DEPTH));
				roll = $urandom_range(0, 99);
				if (roll < 10)
					word = '0;
				else if (roll < 20)
					word = '1;
				else
					word = $urandom;
				issue_operation(opcode, idx, word);
				sent++;
			end
		end
	endtask

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		operation = '0;
		index = '0;
		value = '0;
		sender_idle_pct = 30;
		receiver_stall_pct = 68;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed part. Every read or removal on the empty array must fail, as must an
		// insert past the count. The array is then built from both ends and from the
		// middle, including an insert exactly at the count, probed at and past its end,
		// shrunk again by each kind of removal, topped up by one push and finally cleared twice.
		issue_operation(OP_POP_FRONT, '0, '0);
		issue_operation(OP_POP_BACK, '0, '0);
		issue_operation(OP_REMOVE_AT, '0, '0);
		issue_operation(OP_FRONT, '0, '0);
		issue_operation(OP_BACK, '0, '0);
		issue_operation(OP_READ_AT, '0, '0);
		issue_operation(OP_INSERT_AT, IDX_W'(1), '1);
		issue_operation(OP_PUSH_BACK, '0, '1);
		issue_operation(OP_PUSH_FRONT, '1, '0);
		issue_operation(OP_INSERT_AT, IDX_W'(1), 32'hA5A5_A5A5);
		issue_operation(OP_INSERT_AT, IDX_W'(3), 32'h5A5A_5A5A);
		issue_operation(OP_INSERT_AT, IDX_W'(5), 32'h1234_5678);
		issue_operation(OP_READ_AT, '1, '0);
		issue_operation(OP_READ_AT, IDX_W'(4), '0);
		issue_operation(OP_READ_AT, IDX_W'(3), '0);
		issue_operation(OP_FRONT, '0, '0);
		issue_operation(OP_BACK, '0, '0);
		issue_operation(OP_REMOVE_AT, IDX_W'(1), '0);
		issue_operation(OP_POP_BACK, '0, '0);
		// Unknown operation codes must leave the array and its count alone.
		issue_operation(OP_W'((1 << OP_W) - 1), IDX_W'(0), '1);
		issue_operation(OP_W'(OP_CLEAR + 1), IDX_W'(0), 32'hDEAD_BEEF);
		issue_operation(OP_POP_FRONT, '0, '0);
		issue_operation(OP_PUSH_BACK, '0, 32'h0000_0001);
		issue_operation(OP_CLEAR, '0, '0);
		issue_operation(OP_CLEAR, '0, '0);

		// Three random phases: a slow receiver, then a slow sender, then full speed.
		// Between phases the sender waits until every result has been taken.
		run_random_phase(30, 68, ITEMS_PER_PHASE);
		wait_for_results();
		run_random_phase(68, 30, ITEMS_PER_PHASE);
		wait_for_results();
		run_random_phase(0, 0, ITEMS_PER_PHASE);
		wait_for_results();

		// The bench idles before the verdict so that a stray extra result would still be caught.
		repeat (8) @(negedge clk);
		if (mismatches == 0 && pending == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end
endmodule
